### hdl/spww_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled pixel window writer package
// Shared payload types, control structs and bus command codes.
// ----------------------------------------------------------------------------
package spww_pkg;

	// Display controller commands
	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_PAGE   = 8'h2B;
	localparam logic [7:0] CMD_WRITE  = 8'h2C;

	// Register indexes (paddr[2])
	localparam logic REG_ON_COLOR  = 1'b0;
	localparam logic REG_OFF_COLOR = 1'b1;

	localparam logic [15:0] ON_COLOR_RST  = 16'h0000;
	localparam logic [15:0] OFF_COLOR_RST = 16'hFFFF;

	// Header is 11 bytes: two 5-byte window commands plus the write command
	localparam logic [3:0] HDR_LAST = 4'd10;

	typedef struct packed {
		logic [8:0] cell_x;
		logic [8:0] cell_y;
		logic       pixel_on;
		logic [2:0] scale;
	} item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       is_data;
		logic       last;
	} result_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic emit_hdr;
		logic emit_pix;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic pix_none;
		logic pix_last;
	} dp_status_t;

endpackage

### hdl/spww_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color register file
// APB-style slave holding the on and off pixel colors.
// ----------------------------------------------------------------------------
module spww_regs
	import spww_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] on_color,
	output logic [15:0] off_color
);

	logic [15:0] on_color_q;
	logic [15:0] off_color_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_color_q  <= ON_COLOR_RST;
			off_color_q <= OFF_COLOR_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ON_COLOR:  on_color_q  <= pwdata[15:0];
				REG_OFF_COLOR: off_color_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ON_COLOR:  prdata = {16'h0000, on_color_q};
			REG_OFF_COLOR: prdata = {16'h0000, off_color_q};
			default:       prdata = 32'h0000_0000;
		endcase
	end

	assign on_color  = on_color_q;
	assign off_color = off_color_q;

endmodule

### hdl/spww_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window writer datapath
// Captures the cell, scales the address window and serializes bus bytes.
// ----------------------------------------------------------------------------
module spww_dpath
	import spww_pkg::*;
#(
	parameter int MAX_SCALE = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic [15:0] on_color,
	input  logic [15:0] off_color,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	output result_t    result,
	output logic       result_valid
);

	localparam int CNT_W = $clog2(2 * MAX_SCALE * MAX_SCALE + 1);

	logic [8:0]       cx_q;
	logic [8:0]       cy_q;
	logic [2:0]       sc_q;
	logic [15:0]      color_q;
	logic [15:0]      x0_q, x1_q, y0_q, y1_q;
	logic [3:0]       hdr_q;
	logic [CNT_W-1:0] pix_rem_q;
	result_t          result_q;
	logic             result_valid_q;

	logic [2:0]  sc_sat;
	logic [11:0] x0_prod, y0_prod;
	logic [15:0] x0_ext, y0_ext;
	logic [5:0]  sq;
	logic [6:0]  pix_bytes;
	logic [7:0]  hdr_byte;
	logic        hdr_is_data;

	// Clamp oversized scale
	assign sc_sat = (item.scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : item.scale;

	assign x0_prod   = 12'(cx_q) * 12'(sc_q);
	assign y0_prod   = 12'(cy_q) * 12'(sc_q);
	assign x0_ext    = {4'h0, x0_prod};
	assign y0_ext    = {4'h0, y0_prod};
	assign sq        = 6'(sc_q) * 6'(sc_q);
	assign pix_bytes = {sq, 1'b0};

	always_comb begin
		hdr_is_data = 1'b1;
		unique case (hdr_q)
			4'd0: begin
				hdr_byte    = CMD_COLUMN;
				hdr_is_data = 1'b0;
			end
			4'd1: hdr_byte = x0_q[15:8];
			4'd2: hdr_byte = x0_q[7:0];
			4'd3: hdr_byte = x1_q[15:8];
			4'd4: hdr_byte = x1_q[7:0];
			4'd5: begin
				hdr_byte    = CMD_PAGE;
				hdr_is_data = 1'b0;
			end
			4'd6: hdr_byte = y0_q[15:8];
			4'd7: hdr_byte = y0_q[7:0];
			4'd8: hdr_byte = y1_q[15:8];
			4'd9: hdr_byte = y1_q[7:0];
			default: begin
				hdr_byte    = CMD_WRITE;
				hdr_is_data = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= item.cell_x;
			cy_q    <= item.cell_y;
			sc_q    <= sc_sat;
			color_q <= item.pixel_on ? on_color : off_color;
		end
		if (cmd.calc) begin
			// Window end wraps: scale zero gives start minus one
			x0_q      <= x0_ext;
			y0_q      <= y0_ext;
			x1_q      <= x0_ext + 16'(sc_q) - 16'd1;
			y1_q      <= y0_ext + 16'(sc_q) - 16'd1;
			hdr_q     <= 4'd0;
			pix_rem_q <= pix_bytes[CNT_W-1:0];
		end
		if (cmd.emit_hdr) begin
			hdr_q <= hdr_q + 4'd1;
		end
		if (cmd.emit_pix) begin
			pix_rem_q <= pix_rem_q - CNT_W'(1);
		end
		if (cmd.emit_hdr) begin
			result_q.bus_byte <= hdr_byte;
			result_q.is_data  <= hdr_is_data;
			result_q.last     <= (hdr_q == HDR_LAST) && (pix_rem_q == '0);
		end else if (cmd.emit_pix) begin
			// Even count remaining means the high byte of a pixel
			result_q.bus_byte <= pix_rem_q[0] ? color_q[7:0] : color_q[15:8];
			result_q.is_data  <= 1'b1;
			result_q.last     <= (pix_rem_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_hdr || cmd.emit_pix;
		end
	end

	assign status.hdr_last = (hdr_q == HDR_LAST);
	assign status.pix_none = (pix_rem_q == '0);
	assign status.pix_last = (pix_rem_q == CNT_W'(1));
	assign result          = result_q;
	assign result_valid    = result_valid_q;

endmodule

### hdl/spww_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window writer controller
// Sequences capture, address calculation, header and pixel transfers.
// ----------------------------------------------------------------------------
module spww_ctrl
	import spww_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_HDR,
		S_PIX
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CALC;
						busy_q  <= 1'b1;
					end
				end
				S_CALC: state_q <= S_HDR;
				S_HDR: begin
					if (status.hdr_last) begin
						if (status.pix_none) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
						end else begin
							state_q <= S_PIX;
						end
					end
				end
				S_PIX: begin
					if (status.pix_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load     = (state_q == S_IDLE) && start;
	assign cmd.calc     = (state_q == S_CALC);
	assign cmd.emit_hdr = (state_q == S_HDR);
	assign cmd.emit_pix = (state_q == S_PIX);
	assign busy         = busy_q;

endmodule

### hdl/scaled_pixel_window_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled pixel window writer
// After start is accepted, the controller loads the item, computes the window in
// S_CALC, then emits header bytes in S_HDR and pixel bytes in S_PIX.
// Throughput: one byte per cycle in S_HDR/S_PIX; start is only taken when idle.
// The byte sequencer in the controller sets this rate; the receiver cannot stall.
// Reset clears the controller and strobe, on_color to 0x0000, off_color to 0xFFFF.
// ----------------------------------------------------------------------------
module scaled_pixel_window_writer_top
	import spww_pkg::*;
#(
	parameter int MAX_SCALE = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output result_t     result,
	output logic        result_valid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] on_color;
	logic [15:0] off_color;
	ctrl_cmd_t   cmd;
	dp_status_t  status;
	logic        busy_int;

	spww_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.on_color  (on_color),
		.off_color (off_color)
	);

	spww_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy_int)
	);

	spww_dpath #(
		.MAX_SCALE (MAX_SCALE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.on_color     (on_color),
		.off_color    (off_color),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	assign busy = busy_int;

endmodule

### hdl/spww_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window writer port checker
// Temporal checks on the top-level ports, bound into the top level.
// ----------------------------------------------------------------------------
module spww_checker
	import spww_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input result_t result,
	input logic    result_valid
);

	// An accepted transfer raises busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after start");

	// No result strobe directly follows an accepted start
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result strobe right after start");

	// Strobes outside busy only for the final byte
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !busy) |-> result.last)
		else $error("non-final byte while idle");

	// Final byte ends the burst
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !result_valid)
		else $error("strobe after final byte");

	// Sequence opens with the column command
	a_first_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !$past(result_valid)) |->
			(result.bus_byte == CMD_COLUMN && !result.is_data))
		else $error("sequence does not open with column command");

endmodule

bind scaled_pixel_window_writer_top spww_checker u_spww_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result       (result),
	.result_valid (result_valid)
);
